[rtl/core/tts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants for the timed text slot table.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int TEXT_LIMIT_DEF = 64;
  localparam int CHAR_W         = 8;
  localparam int TIME_W         = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_COMMIT = 2'd1,
    OP_TAKE   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_NONE_DUE  = 2'd2,
    KIND_TEXT      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TAKE = 2'b10
  } state_t;

endpackage

[rtl/core/tts_text_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_text_ram
// Text byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tts_text_ram #(
  parameter int ADDR_W = 9
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [tts_pkg::CHAR_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [tts_pkg::CHAR_W-1:0] rd_data
);
  import tts_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/timed_text_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_text_slot_table
// Slot table of short text messages with release times. Text is staged in a
// spare buffer of the text memory; a commit hands that buffer to the lowest
// free slot and takes the slot's old buffer for staging, so no copy is made.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_ready   opcode, text_char, time_value
//   out_     output     out_valid/out_ready result_kind, out_char, last_byte
//
// append, commit, an ignored opcode and a take with nothing due complete without leaving idle.
// a take that releases a slot of n bytes sends one byte per cycle while the output is not stalled,
// through the single read port of the text memory (registered read data).
// a stalled output holds off the next input and extends a take by the stalled cycles.
// reset clears control state; the text memory is not cleared.
// ----------------------------------------------------------------------------
module timed_text_slot_table #(
  parameter int SLOT_COUNT = tts_pkg::SLOT_COUNT_DEF,
  parameter int TEXT_LIMIT = tts_pkg::TEXT_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [tts_pkg::CHAR_W-1:0] in_text_char,
  input  logic [tts_pkg::TIME_W-1:0] in_time_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_result_kind,
  output logic [tts_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last_byte
);
  import tts_pkg::*;

  localparam int IDX_W  = $clog2(TEXT_LIMIT);
  localparam int CW     = $clog2(TEXT_LIMIT + 2);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BUF_W  = $clog2(SLOT_COUNT + 1);
  localparam int ADDR_W = BUF_W + IDX_W;

  localparam logic [CW-1:0] LIMIT_C = CW'(TEXT_LIMIT);
  localparam logic [CW-1:0] OVER_C  = CW'(TEXT_LIMIT + 1);

  // control state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       stage_count_r, stage_count_nxt;
  logic [BUF_W-1:0]    stage_buf_r, stage_buf_nxt;
  logic [BUF_W-1:0]    map_r [SLOT_COUNT];
  logic [BUF_W-1:0]    map_nxt [SLOT_COUNT];
  logic                active_r [SLOT_COUNT];
  logic                active_nxt [SLOT_COUNT];
  logic                out_valid_r, out_valid_nxt;
  logic                byte_vld_r, byte_vld_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic [CW-1:0]       snt_r, snt_nxt;

  // payload
  logic [CW-1:0]       slot_len_r [SLOT_COUNT];
  logic [CW-1:0]       slot_len_nxt [SLOT_COUNT];
  logic [TIME_W-1:0]   slot_due_r [SLOT_COUNT];
  logic [TIME_W-1:0]   slot_due_nxt [SLOT_COUNT];
  logic [BUF_W-1:0]    rd_buf_r, rd_buf_nxt;
  logic [CW-1:0]       take_len_r, take_len_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  // search results
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic                due_found;
  logic [SLOT_W-1:0]   due_idx;
  logic [TIME_W-1:0]   diff [SLOT_COUNT];

  logic                out_free;
  logic                in_fire;
  logic                move;
  logic                issue;
  logic                last_move;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CHAR_W-1:0]   rd_data;

  tts_text_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_text_char),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // lowest free slot and lowest due slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    due_found  = 1'b0;
    due_idx    = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      diff[i] = in_time_value - slot_due_r[i];
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      // wrap-safe: due once now minus due is non-negative
      if (active_r[i] && !diff[i][TIME_W-1]) begin
        due_found = 1'b1;
        due_idx   = SLOT_W'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign move      = (state_r == ST_TAKE) && byte_vld_r && out_free;
  assign last_move = move && ((snt_r + CW'(1)) == take_len_r);
  assign issue     = (state_r == ST_TAKE) && (!byte_vld_r || move) && (iss_r < take_len_r);

  assign wr_addr = {stage_buf_r, stage_count_r[IDX_W-1:0]};
  assign rd_addr = {rd_buf_r, iss_r[IDX_W-1:0]};
  assign rd_en   = issue;

  always_comb begin
    state_nxt       = state_r;
    stage_count_nxt = stage_count_r;
    stage_buf_nxt   = stage_buf_r;
    map_nxt         = map_r;
    active_nxt      = active_r;
    slot_len_nxt    = slot_len_r;
    slot_due_nxt    = slot_due_r;
    out_valid_nxt   = out_valid_r;
    byte_vld_nxt    = byte_vld_r;
    iss_nxt         = iss_r;
    snt_nxt         = snt_r;
    rd_buf_nxt      = rd_buf_r;
    take_len_nxt    = take_len_r;
    out_kind_nxt    = out_kind_r;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            OP_APPEND: begin
              if (stage_count_r < LIMIT_C) begin
                wr_en           = 1'b1;
                stage_count_nxt = stage_count_r + CW'(1);
              end else begin
                stage_count_nxt = OVER_C;
              end
            end
            OP_COMMIT: begin
              stage_count_nxt = '0;
              out_valid_nxt   = 1'b1;
              out_char_nxt    = '0;
              out_last_nxt    = 1'b1;
              if (stage_count_r != '0 && stage_count_r <= LIMIT_C && free_found) begin
                out_kind_nxt           = KIND_SCHEDULED;
                active_nxt[free_idx]   = 1'b1;
                slot_len_nxt[free_idx] = stage_count_r;
                slot_due_nxt[free_idx] = in_time_value;
                // staged buffer goes to the slot, the slot's old buffer stages
                map_nxt[free_idx]      = stage_buf_r;
                stage_buf_nxt          = map_r[free_idx];
              end else begin
                out_kind_nxt = KIND_REJECTED;
              end
            end
            OP_TAKE: begin
              if (due_found) begin
                active_nxt[due_idx] = 1'b0;
                rd_buf_nxt          = map_r[due_idx];
                take_len_nxt        = slot_len_r[due_idx];
                iss_nxt             = '0;
                snt_nxt             = '0;
                byte_vld_nxt        = 1'b0;
                state_nxt           = ST_TAKE;
              end else begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_NONE_DUE;
                out_char_nxt  = '0;
                out_last_nxt  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TAKE: begin
        if (move) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TEXT;
          out_char_nxt  = rd_data;
          out_last_nxt  = last_move;
          snt_nxt       = snt_r + CW'(1);
          if (last_move) begin
            state_nxt = ST_IDLE;
          end
        end
        // read data register holds until its byte is transferred
        if (issue) begin
          iss_nxt      = iss_r + CW'(1);
          byte_vld_nxt = 1'b1;
        end else if (move) begin
          byte_vld_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stage_count_r <= '0;
      stage_buf_r   <= BUF_W'(SLOT_COUNT);
      out_valid_r   <= 1'b0;
      byte_vld_r    <= 1'b0;
      iss_r         <= '0;
      snt_r         <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        map_r[i]    <= BUF_W'(i);
        active_r[i] <= 1'b0;
      end
    end else begin
      state_r       <= state_nxt;
      stage_count_r <= stage_count_nxt;
      stage_buf_r   <= stage_buf_nxt;
      out_valid_r   <= out_valid_nxt;
      byte_vld_r    <= byte_vld_nxt;
      iss_r         <= iss_nxt;
      snt_r         <= snt_nxt;
      map_r         <= map_nxt;
      active_r      <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_len_r <= slot_len_nxt;
    slot_due_r <= slot_due_nxt;
    rd_buf_r   <= rd_buf_nxt;
    take_len_r <= take_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_char        = out_char_r;
  assign out_last_byte   = out_last_r;

endmodule
